/* rtl/core/refcounted_page_bitmap_allocator_unit_defines.svh */
// assertion macros for the page allocator
`ifndef REFCOUNTED_PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define REFCOUNTED_PAGE_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define RPBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RPBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rpba_pkg.sv */
package rpba_pkg;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 12;
    localparam int STS_W      = 2;
    localparam int OUT_REF_W  = 16;
    localparam int TOTAL_W    = 13;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
    localparam logic [TOTAL_W-1:0] USED_MAX    = 13'd8191;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REF     = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK      = 2'd0,
        STS_NO_PAGE = 2'd1,
        STS_RANGE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

/* rtl/core/refcounted_page_bitmap_allocator_unit.sv */
// Page allocator with a used bitmap and per-page reference counts.
// Input channel s_axis: one item is a command and a page number. Output
// channel m_axis: one result item per input item with status, page, the
// page's reference count and the number of used pages after the command.
// i_cfg_we/i_cfg_wdata write the page limit and reload the used-page counter;
// write it only while no item is in flight.
// Free, add reference and release read the count and bitmap word, update
// them in the update state and present the result from the output state.
// Allocate walks the bitmap one 64-bit word per cycle through a single
// find-first-free unit until a free page is found or the limit is reached,
// scanning 1 to ceil(NUM_PAGES/64) words (64 at the default size).
// An out-of-range index or an empty limit answers in the cycle after the item is taken.
// Only one item is in the block at a time: s_axis_tready is low from
// acceptance until the result has been taken, so a stalled receiver holds
// the result and the input side waits.
// After reset a clearing pass over every page sets every used bit and
// zeroes every count; s_axis_tready stays low meanwhile, config writes are
// taken as usual.
`include "refcounted_page_bitmap_allocator_unit_defines.svh"

module refcounted_page_bitmap_allocator_unit #(
    parameter int NUM_PAGES = 4096,
    parameter int REF_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rpba_pkg::TOTAL_W-1:0]        i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // command[1:0], page[13:2]
    input  logic [rpba_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], result_page[13:2], ref_count_after[29:14], used_pages[42:30]
    output logic [rpba_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int PW    = $clog2(NUM_PAGES);
    localparam int WORDS = (NUM_PAGES + 63) / 64;
    localparam int WW    = (PW > 7) ? PW - 6 : 1;
    localparam int CMPW  = (PW + 2 > 14) ? PW + 2 : 14;
    localparam logic [REF_WIDTH-1:0] REF_MAX = '1;

    rpba_pkg::t_state  r_state, n_state;
    rpba_pkg::t_cmd    r_cmd, n_cmd;
    rpba_pkg::t_status r_status, n_status;
    logic [PW-1:0]                   r_idx, n_idx;
    logic [WW:0]                     r_w, n_w;
    logic [PW-1:0]                   r_clr, n_clr;
    logic [rpba_pkg::TOTAL_W-1:0]    r_total, n_total;
    logic [rpba_pkg::TOTAL_W-1:0]    r_used, n_used;
    logic [rpba_pkg::IDX_W-1:0]      r_page, n_page;
    logic [rpba_pkg::OUT_REF_W-1:0]  r_refs, n_refs;

    rpba_pkg::t_cmd in_cmd;
    logic [rpba_pkg::IDX_W-1:0] in_idx;
    logic [PW-1:0]              in_page;
    logic [CMPW-1:0]            limit;
    logic                       in_range;
    logic                       accept;
    logic [WW:0]                w_next;
    logic [CMPW-1:0]            base;
    logic [CMPW-1:0]            next_base;
    logic [CMPW-1:0]            span_full;
    logic [rpba_pkg::BIT_W:0]   span;
    logic [PW-1:0]              found_page;

    rpba_pkg::t_mem_ctl          bm_ctl;
    logic [WW-1:0]               bm_waddr, bm_raddr;
    logic [rpba_pkg::WORD_W-1:0] bm_wdata, bm_rdata;
    rpba_pkg::t_mem_ctl          rf_ctl;
    logic [PW-1:0]               rf_waddr, rf_raddr;
    logic [REF_WIDTH-1:0]        rf_wdata, rf_rdata;

    logic                        sc_found;
    logic [rpba_pkg::BIT_W-1:0]  sc_bit;
    logic [rpba_pkg::WORD_W-1:0] sc_onehot;

    logic [REF_WIDTH-1:0]        ref_new;
    logic                        do_clr;
    logic [rpba_pkg::BIT_W-1:0]  upd_bit;

    rpba_ram #(
        .WIDTH  (rpba_pkg::WORD_W),
        .DEPTH  (WORDS),
        .ADDR_W (WW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_ctl   (bm_ctl),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    rpba_ram #(
        .WIDTH  (REF_WIDTH),
        .DEPTH  (NUM_PAGES),
        .ADDR_W (PW)
    ) u_refs (
        .i_clk   (i_clk),
        .i_ctl   (rf_ctl),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    rpba_scan u_scan (
        .i_free   (~bm_rdata),
        .i_span   (span),
        .o_found  (sc_found),
        .o_bit    (sc_bit),
        .o_onehot (sc_onehot)
    );

    assign s_axis_tready = (r_state == rpba_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == rpba_pkg::ST_OUT);
    assign m_axis_tdata  = {5'b0, r_used, r_refs, r_page, r_status};

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign in_cmd    = rpba_pkg::t_cmd'(s_axis_tdata[1:0]);
    assign in_idx    = s_axis_tdata[13:2];
    assign in_page   = PW'(in_idx);
    assign limit     = (CMPW'(r_total) > CMPW'(NUM_PAGES)) ? CMPW'(NUM_PAGES)
                                                           : CMPW'(r_total);
    assign in_range  = CMPW'(in_idx) < limit;
    assign w_next    = r_w + 1'b1;
    assign base      = CMPW'({r_w, 6'b0});
    assign next_base = CMPW'({w_next, 6'b0});
    assign span_full = limit - base;
    assign span      = (span_full >= CMPW'(rpba_pkg::WORD_W)) ?
                       (rpba_pkg::BIT_W + 1)'(rpba_pkg::WORD_W) :
                       span_full[rpba_pkg::BIT_W:0];
    assign found_page = PW'(base + CMPW'(sc_bit));
    assign upd_bit    = r_idx[rpba_pkg::BIT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpba_pkg::ST_CLEAR: begin
                if (r_clr == PW'(NUM_PAGES - 1)) begin
                    n_state = rpba_pkg::ST_IDLE;
                end
            end
            rpba_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == rpba_pkg::CMD_ALLOC) begin
                        n_state = (limit == '0) ? rpba_pkg::ST_OUT : rpba_pkg::ST_SCAN;
                    end else begin
                        n_state = in_range ? rpba_pkg::ST_UPD : rpba_pkg::ST_OUT;
                    end
                end
            end
            rpba_pkg::ST_SCAN: begin
                if (sc_found || !(next_base < limit)) begin
                    n_state = rpba_pkg::ST_OUT;
                end
            end
            rpba_pkg::ST_UPD: begin
                n_state = rpba_pkg::ST_OUT;
            end
            rpba_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = rpba_pkg::ST_IDLE;
                end
            end
            default: n_state = rpba_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cmd    = r_cmd;
        n_status = r_status;
        n_idx    = r_idx;
        n_w      = r_w;
        n_clr    = r_clr;
        n_total  = r_total;
        n_used   = r_used;
        n_page   = r_page;
        n_refs   = r_refs;
        bm_ctl   = '0;
        bm_waddr = '0;
        bm_wdata = '0;
        bm_raddr = '0;
        rf_ctl   = '0;
        rf_waddr = '0;
        rf_wdata = '0;
        rf_raddr = '0;
        ref_new  = rf_rdata;
        do_clr   = 1'b0;
        unique case (r_state)
            rpba_pkg::ST_CLEAR: begin
                rf_ctl.we = 1'b1;
                rf_waddr  = r_clr;
                rf_wdata  = '0;
                if (r_clr < PW'(WORDS)) begin
                    bm_ctl.we = 1'b1;
                    bm_waddr  = WW'(r_clr);
                    bm_wdata  = '1;
                end
                n_clr = r_clr + 1'b1;
            end
            rpba_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cmd  = in_cmd;
                    n_idx  = in_page;
                    n_page = in_idx;
                    n_w    = '0;
                    if (in_cmd == rpba_pkg::CMD_ALLOC) begin
                        bm_ctl.re = 1'b1;
                        bm_raddr  = '0;
                        n_status  = rpba_pkg::STS_NO_PAGE;
                        n_page    = '0;
                        n_refs    = '0;
                    end else if (in_range) begin
                        bm_ctl.re = 1'b1;
                        bm_raddr  = WW'(in_page >> 6);
                        rf_ctl.re = 1'b1;
                        rf_raddr  = in_page;
                    end else begin
                        n_status = rpba_pkg::STS_RANGE;
                        n_refs   = '0;
                    end
                end
            end
            rpba_pkg::ST_SCAN: begin
                if (sc_found) begin
                    bm_ctl.we = 1'b1;
                    bm_waddr  = r_w[WW-1:0];
                    bm_wdata  = bm_rdata | sc_onehot;
                    rf_ctl.we = 1'b1;
                    rf_waddr  = found_page;
                    rf_wdata  = REF_WIDTH'(1);
                    if (r_used != rpba_pkg::USED_MAX) begin
                        n_used = r_used + 1'b1;
                    end
                    n_status = rpba_pkg::STS_OK;
                    n_page   = rpba_pkg::IDX_W'(found_page);
                    n_refs   = rpba_pkg::OUT_REF_W'(1);
                end else if (next_base < limit) begin
                    bm_ctl.re = 1'b1;
                    bm_raddr  = w_next[WW-1:0];
                    n_w       = w_next;
                end else begin
                    n_status = rpba_pkg::STS_NO_PAGE;
                    n_page   = '0;
                    n_refs   = '0;
                end
            end
            rpba_pkg::ST_UPD: begin
                case (r_cmd)
                    rpba_pkg::CMD_FREE: begin
                        ref_new = (rf_rdata != '0) ? rf_rdata - 1'b1 : '0;
                        do_clr  = (ref_new == '0);
                    end
                    rpba_pkg::CMD_REF: begin
                        ref_new = (rf_rdata != REF_MAX) ? rf_rdata + 1'b1 : rf_rdata;
                    end
                    default: begin
                        do_clr = 1'b1;
                    end
                endcase
                bm_ctl.we = 1'b1;
                bm_waddr  = WW'(r_idx >> 6);
                bm_wdata  = do_clr ? (bm_rdata & ~(rpba_pkg::WORD_W'(1) << upd_bit))
                                   : bm_rdata;
                rf_ctl.we = 1'b1;
                rf_waddr  = r_idx;
                rf_wdata  = ref_new;
                if (do_clr && bm_rdata[upd_bit] && (r_used != '0)) begin
                    n_used = r_used - 1'b1;
                end
                n_status = rpba_pkg::STS_OK;
                n_refs   = rpba_pkg::OUT_REF_W'(ref_new);
            end
            rpba_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
        if (i_cfg_we) begin
            n_total = i_cfg_wdata;
            n_used  = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpba_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_total <= rpba_pkg::TOTAL_RESET;
            r_used  <= rpba_pkg::TOTAL_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_total <= n_total;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_w      <= n_w;
        r_page   <= n_page;
        r_refs   <= n_refs;
    end

    `RPBA_ASSERT_SAME(a_one_in_flight, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
    `RPBA_ASSERT_SAME(a_scan_below_limit, r_state == rpba_pkg::ST_SCAN, base < limit, "scan word beyond limit")
    `RPBA_ASSERT_SAME(a_alloc_count_one, (r_state == rpba_pkg::ST_OUT) && (r_cmd == rpba_pkg::CMD_ALLOC) && (r_status == rpba_pkg::STS_OK), r_refs == 16'd1, "allocated page count not one")
    `RPBA_ASSERT_NEXT(a_upd_to_out, r_state == rpba_pkg::ST_UPD, r_state == rpba_pkg::ST_OUT, "update did not yield a result")

endmodule

/* rtl/core/rpba_ram.sv */
module rpba_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                 i_clk,
    input  rpba_pkg::t_mem_ctl   i_ctl,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_W-1:0]    i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/rpba_scan.sv */
module rpba_scan (
    input  logic [rpba_pkg::WORD_W-1:0] i_free,
    input  logic [rpba_pkg::BIT_W:0]    i_span,
    output logic                        o_found,
    output logic [rpba_pkg::BIT_W-1:0]  o_bit,
    output logic [rpba_pkg::WORD_W-1:0] o_onehot
);

    logic [rpba_pkg::WORD_W-1:0] mask;
    logic [rpba_pkg::WORD_W-1:0] avail;
    logic [rpba_pkg::WORD_W-1:0] onehot;
    logic [rpba_pkg::BIT_W-1:0]  bit_idx;

    always_comb begin
        if (i_span >= (rpba_pkg::BIT_W + 1)'(rpba_pkg::WORD_W)) begin
            mask = '1;
        end else begin
            mask = (rpba_pkg::WORD_W'(1) << i_span[rpba_pkg::BIT_W-1:0]) - 1'b1;
        end
        avail  = i_free & mask;
        // isolate lowest set bit
        onehot = avail & (~avail + 1'b1);
        bit_idx = '0;
        for (int i = 0; i < rpba_pkg::WORD_W; i++) begin
            if (onehot[i]) begin
                bit_idx = bit_idx | rpba_pkg::BIT_W'(i);
            end
        end
    end

    assign o_found  = (avail != '0);
    assign o_bit    = bit_idx;
    assign o_onehot = onehot;

endmodule
